FILE: hdl/pnguf_pkg.sv
// Shared types and constants for the PNG scanline unfilter.
`default_nettype none
package pnguf_pkg;

  // Default sizes handed to the top level parameters
  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;
  localparam int MAX_BPP_DEF    = 4;

  // Width of clamped dimension values (holds up to 65536)
  localparam int DIM_W = 17;

  // Bits of a byte position within a pixel (up to 8 bytes per pixel)
  localparam int SLOT_W = 3;

  // Entries of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Register reset values
  localparam logic [2:0]  BPP_RESET    = 3'd4;
  localparam logic [12:0] WIDTH_RESET  = 13'd1;
  localparam logic [12:0] HEIGHT_RESET = 13'd1;

  // Largest legal filter code
  localparam logic [7:0] FILTER_MAX = 8'd4;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filter_t;

  typedef enum logic [1:0] {
    REG_BPP    = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } cfg_reg_t;

  // Per-byte control handed from front to back
  typedef struct packed {
    filter_t           filter;
    logic              bad;
    logic              first_col;
    logic              first_row;
    logic              last_col;
    logic              last_row;
    logic [SLOT_W-1:0] slot;
  } item_ctl_t;

endpackage
`default_nettype wire

FILE: hdl/pnguf_front.sv
// Front end: splits filter bytes from data bytes and tracks row position.
`default_nettype none
module pnguf_front #(
  parameter int MAX_WIDTH  = pnguf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = pnguf_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_BPP    = pnguf_pkg::MAX_BPP_DEF,
  localparam int KW = $clog2(MAX_BPP),
  localparam int CW = $clog2(MAX_WIDTH * MAX_BPP),
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
  localparam int LW = pnguf_pkg::DIM_W + 1
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic [KW-1:0]            bpp_m1,
  input  wire logic [pnguf_pkg::DIM_W-1:0] eff_width,
  input  wire logic [pnguf_pkg::DIM_W-1:0] eff_height,
  input  wire logic                     in_valid,
  input  wire logic [7:0]               in_byte,
  output logic                          in_ready,
  input  wire logic                     q_full,
  output logic                          push,
  output logic [7:0]                    push_byte,
  output logic [CW-1:0]                 push_col,
  output pnguf_pkg::item_ctl_t          push_ctl
);

  logic                expect_filter;
  pnguf_pkg::filter_t  filter;
  logic                bad;
  logic [CW-1:0]       col;
  logic [KW-1:0]       res [3:MAX_BPP];
  logic [KW-1:0]       k;
  logic [RW-1:0]       row;
  logic [LW-1:0]       row_len;
  logic                fire;
  logic                last_col;
  logic                last_row;

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;
  assign push     = fire && !expect_filter;

  // Row length in bytes follows the registers at once
  assign row_len  = LW'(bpp_m1) * LW'(eff_width) + LW'(eff_width);
  assign last_col = (LW'(col) + LW'(1)) >= row_len;
  assign last_row = (pnguf_pkg::DIM_W'(row) + pnguf_pkg::DIM_W'(1)) >= eff_height;

  // Byte position within the pixel for the pixel size now in force
  always_comb begin
    k = res[3];
    for (int m = 4; m <= MAX_BPP; m++) begin
      if (bpp_m1 == KW'(m - 1)) k = res[m];
    end
  end

  assign push_byte = in_byte;
  assign push_col  = col;
  always_comb begin
    push_ctl.filter    = filter;
    push_ctl.bad       = bad;
    push_ctl.first_col = (col == '0);
    push_ctl.first_row = (row == '0);
    push_ctl.last_col  = last_col;
    push_ctl.last_row  = last_col && last_row;
    push_ctl.slot      = pnguf_pkg::SLOT_W'(k);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_filter <= 1'b1;
      filter        <= pnguf_pkg::FILT_NONE;
      bad           <= 1'b0;
      col           <= '0;
      row           <= '0;
      for (int m = 3; m <= MAX_BPP; m++) res[m] <= '0;
    end else if (fire) begin
      if (expect_filter) begin
        // Out-of-range code: pass the row through and flag it
        if (in_byte > pnguf_pkg::FILTER_MAX) begin
          bad    <= 1'b1;
          filter <= pnguf_pkg::FILT_NONE;
        end else begin
          bad    <= 1'b0;
          filter <= pnguf_pkg::filter_t'(in_byte[2:0]);
        end
        expect_filter <= 1'b0;
        col           <= '0;
        for (int m = 3; m <= MAX_BPP; m++) res[m] <= '0;
      end else if (last_col) begin
        expect_filter <= 1'b1;
        col           <= '0;
        for (int m = 3; m <= MAX_BPP; m++) res[m] <= '0;
        row           <= last_row ? '0 : row + RW'(1);
      end else begin
        col <= col + CW'(1);
        // Column residue for every supported pixel size
        for (int m = 3; m <= MAX_BPP; m++) begin
          res[m] <= (res[m] == KW'(m - 1)) ? '0 : res[m] + KW'(1);
        end
      end
    end
  end

  a_row_end_expects_filter: assert property (@(posedge clk) disable iff (rst)
    (push && push_ctl.last_col) |=> expect_filter)
    else $error("row end did not rearm filter byte");

  a_last_row_on_last_col: assert property (@(posedge clk) disable iff (rst)
    (push && push_ctl.last_row) |=> (row == '0))
    else $error("row counter not wrapped after image end");

endmodule
`default_nettype wire

FILE: hdl/pnguf_queue.sv
// Short queue of classified data bytes between front and back.
`default_nettype none
module pnguf_queue #(
  parameter int CW = 14,
  localparam int DEPTH = pnguf_pkg::QUEUE_DEPTH,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire logic [7:0]           push_byte,
  input  wire logic [CW-1:0]        push_col,
  input  wire pnguf_pkg::item_ctl_t push_ctl,
  output logic                      full,
  output logic                      valid,
  input  wire logic                 pop,
  output logic [7:0]                head_byte,
  output logic [CW-1:0]             head_col,
  output pnguf_pkg::item_ctl_t      head_ctl
);

  logic [7:0]           byte_q [DEPTH];
  logic [CW-1:0]        col_q  [DEPTH];
  pnguf_pkg::item_ctl_t ctl_q  [DEPTH];
  logic [AW-1:0]        wr_ptr;
  logic [AW-1:0]        rd_ptr;
  logic [AW:0]          count;

  assign full      = (count == (AW+1)'(DEPTH));
  assign valid     = (count != '0);
  assign head_byte = byte_q[rd_ptr];
  assign head_col  = col_q[rd_ptr];
  assign head_ctl  = ctl_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      byte_q[wr_ptr] <= push_byte;
      col_q[wr_ptr]  <= push_col;
      ctl_q[wr_ptr]  <= push_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + AW'(1);
      if (pop)  rd_ptr <= rd_ptr + AW'(1);
      case ({push, pop})
        2'b10:   count <= count + (AW+1)'(1);
        2'b01:   count <= count - (AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (full && !pop) |=> !$past(push) || (count == (AW+1)'(DEPTH)))
    else $error("queue written while full");

endmodule
`default_nettype wire

FILE: hdl/pnguf_back.sv
// Back end: line store read, filter reconstruction and output register.
`default_nettype none
module pnguf_back #(
  parameter int MAX_WIDTH = pnguf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_BPP   = pnguf_pkg::MAX_BPP_DEF,
  localparam int KW = $clog2(MAX_BPP),
  localparam int LINE_DEPTH = MAX_WIDTH * MAX_BPP,
  localparam int CW = $clog2(LINE_DEPTH)
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 q_valid,
  input  wire logic [7:0]           q_byte,
  input  wire logic [CW-1:0]        q_col,
  input  wire pnguf_pkg::item_ctl_t q_ctl,
  output logic                      q_pop,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [7:0]                m_tdata,
  output logic                      m_tlast,
  output logic [1:0]                m_tuser
);

  logic [7:0]           line_mem [LINE_DEPTH];
  logic [7:0]           mem_q;
  logic                 s1_valid;
  logic [7:0]           s1_byte;
  logic [CW-1:0]        s1_col;
  pnguf_pkg::item_ctl_t s1_ctl;
  logic [7:0]           left_px [MAX_BPP];
  logic [7:0]           upleft_px [MAX_BPP];
  logic [MAX_BPP-1:0]   seen;
  logic [KW-1:0]        slot;
  logic                 live;
  logic                 advance;
  logic [7:0]           a, b, c, pred, r;
  logic [8:0]           ab_sum;
  logic signed [9:0]    sa, sb, sc, da, db, dc;
  logic [9:0]           pa, pb, pc;

  assign advance = s1_valid && (!m_tvalid || m_tready);
  assign q_pop   = q_valid && (!s1_valid || advance);

  // Neighbors: upper from the line store, left and upper-left per byte position;
  // a position not yet written in this row reads as zero
  assign slot = s1_ctl.slot[KW-1:0];
  assign live = !s1_ctl.first_col && seen[slot];
  assign b = s1_ctl.first_row ? 8'd0 : mem_q;
  assign a = live ? left_px[slot] : 8'd0;
  assign c = live ? upleft_px[slot] : 8'd0;

  assign ab_sum = {1'b0, a} + {1'b0, b};
  assign sa = signed'({2'b00, a});
  assign sb = signed'({2'b00, b});
  assign sc = signed'({2'b00, c});
  assign da = sb - sc;
  assign db = sa - sc;
  assign dc = sa + sb - sc - sc;
  assign pa = da[9] ? 10'(-da) : 10'(da);
  assign pb = db[9] ? 10'(-db) : 10'(db);
  assign pc = dc[9] ? 10'(-dc) : 10'(dc);

  always_comb begin
    unique case (s1_ctl.filter)
      pnguf_pkg::FILT_NONE:  pred = 8'd0;
      pnguf_pkg::FILT_SUB:   pred = a;
      pnguf_pkg::FILT_UP:    pred = b;
      pnguf_pkg::FILT_AVG:   pred = ab_sum[8:1];
      pnguf_pkg::FILT_PAETH: begin
        if (pa <= pb && pa <= pc) pred = a;
        else if (pb <= pc)        pred = b;
        else                      pred = c;
      end
      default:               pred = 8'd0;
    endcase
  end

  assign r = s1_byte + pred;

  always_ff @(posedge clk) begin
    if (q_pop) mem_q <= line_mem[q_col];
  end

  always_ff @(posedge clk) begin
    if (advance) line_mem[s1_col] <= r;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_byte <= q_byte;
      s1_col  <= q_col;
      s1_ctl  <= q_ctl;
    end
    if (advance) begin
      left_px[slot]   <= r;
      upleft_px[slot] <= b;
      m_tdata <= r;
      m_tlast <= s1_ctl.last_col;
      m_tuser <= {s1_ctl.bad, s1_ctl.last_row};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
      seen     <= '0;
    end else begin
      if (q_pop)        s1_valid <= 1'b1;
      else if (advance) s1_valid <= 1'b0;
      if (advance)       m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      if (advance) seen <= (s1_ctl.first_col ? '0 : seen) | (MAX_BPP'(1) << slot);
    end
  end

  a_bad_row_unchanged: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_ctl.bad) |=> (m_tdata == $past(s1_byte)) && m_tuser[1])
    else $error("flagged row byte altered");

  a_up_first_row: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_ctl.first_row && s1_ctl.filter == pnguf_pkg::FILT_UP)
      |=> (m_tdata == $past(s1_byte)))
    else $error("up filter on first row used stale line data");

endmodule
`default_nettype wire

FILE: hdl/png_scanline_unfilter_top.sv
// Top level of the PNG scanline unfilter (filters None, Sub, Up, Average, Paeth).
//
//  channel | direction | beat contents
//  --------+-----------+-----------------------------------------------------
//  s_*     | in        | tdata[7:0] stream_byte (filter byte, then row data)
//  m_*     | out       | tdata[7:0] pixel_byte, tlast row_done,
//          |           | tuser[0] image_done, tuser[1] bad_filter
//  cfg_*   | in        | index 0 bytes_per_pixel, 1 image_width, 2 image_height
//
// One byte per cycle sustained while the output is not stalled; a data byte
// passes the queue write, line store read and output register on its way to m_tvalid.
// Filter bytes give no output beat. Reset clears all control state; the line
// store is not cleared and is written by the first row. Either side may stall
// on its own: the queue and output register absorb the difference.
`default_nettype none
module png_scanline_unfilter_top #(
  parameter int MAX_WIDTH  = pnguf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = pnguf_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_BPP    = pnguf_pkg::MAX_BPP_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] stream_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // [7:0] pixel_byte
  output logic             m_tlast,
  output logic [1:0]       m_tuser,   // [0] image_done, [1] bad_filter
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [12:0] cfg_data
);

  localparam int KW = $clog2(MAX_BPP);
  localparam int CW = $clog2(MAX_WIDTH * MAX_BPP);
  localparam int DW = pnguf_pkg::DIM_W;

  logic [2:0]           bpp_reg;
  logic [12:0]          width_reg;
  logic [12:0]          height_reg;
  logic [KW-1:0]        bpp_m1;
  logic [DW-1:0]        eff_width;
  logic [DW-1:0]        eff_height;
  logic                 q_full;
  logic                 push;
  logic [7:0]           push_byte;
  logic [CW-1:0]        push_col;
  pnguf_pkg::item_ctl_t push_ctl;
  logic                 q_valid;
  logic                 q_pop;
  logic [7:0]           q_byte;
  logic [CW-1:0]        q_col;
  pnguf_pkg::item_ctl_t q_ctl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bpp_reg    <= pnguf_pkg::BPP_RESET;
      width_reg  <= pnguf_pkg::WIDTH_RESET;
      height_reg <= pnguf_pkg::HEIGHT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pnguf_pkg::REG_BPP:    bpp_reg    <= cfg_data[2:0];
        pnguf_pkg::REG_WIDTH:  width_reg  <= cfg_data;
        pnguf_pkg::REG_HEIGHT: height_reg <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp registers to the supported range
  always_comb begin
    if (bpp_reg < 3'd3)                bpp_m1 = KW'(2);
    else if (4'(bpp_reg) > 4'(MAX_BPP)) bpp_m1 = KW'(MAX_BPP - 1);
    else                               bpp_m1 = KW'(bpp_reg - 3'd1);

    if (width_reg == '0)                     eff_width = DW'(1);
    else if (DW'(width_reg) > DW'(MAX_WIDTH)) eff_width = DW'(MAX_WIDTH);
    else                                     eff_width = DW'(width_reg);

    if (height_reg == '0)                      eff_height = DW'(1);
    else if (DW'(height_reg) > DW'(MAX_HEIGHT)) eff_height = DW'(MAX_HEIGHT);
    else                                       eff_height = DW'(height_reg);
  end

  pnguf_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_BPP   (MAX_BPP)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .bpp_m1    (bpp_m1),
    .eff_width (eff_width),
    .eff_height(eff_height),
    .in_valid  (s_tvalid),
    .in_byte   (s_tdata),
    .in_ready  (s_tready),
    .q_full    (q_full),
    .push      (push),
    .push_byte (push_byte),
    .push_col  (push_col),
    .push_ctl  (push_ctl)
  );

  pnguf_queue #(
    .CW(CW)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_byte(push_byte),
    .push_col (push_col),
    .push_ctl (push_ctl),
    .full     (q_full),
    .valid    (q_valid),
    .pop      (q_pop),
    .head_byte(q_byte),
    .head_col (q_col),
    .head_ctl (q_ctl)
  );

  pnguf_back #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_BPP  (MAX_BPP)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_byte  (q_byte),
    .q_col   (q_col),
    .q_ctl   (q_ctl),
    .q_pop   (q_pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser)
  );

endmodule
`default_nettype wire

FILE: tb/png_unfilter_checker.sv
// Scoreboard for the PNG scanline unfilter: rebuilds each row byte and checks every pixel beat.
`timescale 1ns / 100ps
module png_unfilter_checker #(
  parameter int MAX_WIDTH  = pnguf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = pnguf_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_BPP    = pnguf_pkg::MAX_BPP_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] stream_byte
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,    // [7:0] pixel_byte
  input  logic        m_tlast,
  input  logic [1:0]  m_tuser,    // [0] image_done, [1] bad_filter
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  output int          pending,
  output int          checked,
  output int          failures
);
  import pnguf_pkg::*;

  localparam int LINE_DEPTH = MAX_WIDTH * MAX_BPP;

  typedef struct packed {
    logic [7:0] pixel;
    logic       row_done;
    logic       image_done;
    logic       bad_filter;
  } pixel_beat_t;

  pixel_beat_t pixel_q[$];

  logic [7:0]  line_mem [LINE_DEPTH];
  logic [7:0]  left_px [MAX_BPP];
  logic [7:0]  upleft_px [MAX_BPP];
  logic [2:0]  reg_bpp;
  logic [12:0] reg_width;
  logic [12:0] reg_height;
  int unsigned col;
  int unsigned row;
  filter_t     row_filt;
  logic        want_filter;
  logic        row_bad;

  function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Take one stream byte: a filter byte opens a row, a data byte yields one pixel beat.
  task automatic rebuild_byte(input logic [7:0] x);
    int unsigned bpp, row_len, rows, k;
    int          a, b, c, p, pa, pb, pc, guess;
    logic [7:0]  r;
    logic        last_col, last_row;
    pixel_beat_t beat;
    if (want_filter) begin
      row_bad = (x > FILTER_MAX);
      row_filt = row_bad ? FILT_NONE : filter_t'(x[2:0]);
      want_filter = 1'b0;
      col = 0;
      for (int i = 0; i < MAX_BPP; i++) begin
        left_px[i] = '0;
        upleft_px[i] = '0;
      end
    end else begin
      bpp = clamp(reg_bpp, 3, MAX_BPP);
      row_len = bpp * clamp(reg_width, 1, MAX_WIDTH);
      rows = clamp(reg_height, 1, MAX_HEIGHT);
      k = col % bpp;
      a = left_px[k];
      c = upleft_px[k];
      b = (row != 0 && col < LINE_DEPTH) ? int'(line_mem[col]) : 0;
      case (row_filt)
        FILT_SUB:   guess = a;
        FILT_UP:    guess = b;
        FILT_AVG:   guess = (a + b) / 2;
        FILT_PAETH: begin
          p = a + b - c;
          pa = (p > a) ? p - a : a - p;
          pb = (p > b) ? p - b : b - p;
          pc = (p > c) ? p - c : c - p;
          if (pa <= pb && pa <= pc) guess = a;
          else if (pb <= pc) guess = b;
          else guess = c;
        end
        default:    guess = 0;
      endcase
      r = x + guess[7:0];
      upleft_px[k] = b[7:0];
      left_px[k] = r;
      if (col < LINE_DEPTH) line_mem[col] = r;
      last_col = (col + 1 >= row_len);
      last_row = 1'b0;
      if (last_col) begin
        last_row = (row + 1 >= rows);
        row = last_row ? 0 : row + 1;
        want_filter = 1'b1;
        col = 0;
      end else begin
        col++;
      end
      beat.pixel = r;
      beat.row_done = last_col;
      beat.image_done = last_row;
      beat.bad_filter = row_bad;
      pixel_q.push_back(beat);
    end
  endtask

  always @(posedge clk) begin
    pixel_beat_t want;
    if (rst) begin
      pixel_q.delete();
      reg_bpp = BPP_RESET;
      reg_width = WIDTH_RESET;
      reg_height = HEIGHT_RESET;
      col = 0;
      row = 0;
      row_filt = FILT_NONE;
      want_filter = 1'b1;
      row_bad = 1'b0;
      for (int i = 0; i < MAX_BPP; i++) begin
        left_px[i] = '0;
        upleft_px[i] = '0;
      end
      checked = 0;
      failures = 0;
    end else begin
      // Compare before pushing: a beat can never leave in the cycle its byte enters.
      if (m_tvalid && m_tready) begin
        checked++;
        if (pixel_q.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("%t: unexpected pixel beat data %02h last %b tuser %b",
                     $realtime, m_tdata, m_tlast, m_tuser);
        end else begin
          want = pixel_q.pop_front();
          if (want.pixel !== m_tdata || want.row_done !== m_tlast ||
              want.image_done !== m_tuser[0] || want.bad_filter !== m_tuser[1]) begin
            failures++;
            if (failures <= 10)
              $display({"%t: pixel beat %0d expected data %02h last %b image_done %b ",
                        "bad_filter %b, got data %02h last %b image_done %b bad_filter %b"},
                       $realtime, checked, want.pixel, want.row_done, want.image_done,
                       want.bad_filter, m_tdata, m_tlast, m_tuser[0], m_tuser[1]);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_BPP:    reg_bpp = cfg_data[2:0];
          REG_WIDTH:  reg_width = cfg_data;
          REG_HEIGHT: reg_height = cfg_data;
          default:    ;
        endcase
      end
      if (s_tvalid && s_tready) rebuild_byte(s_tdata);
    end
    pending = pixel_q.size();
  end

endmodule

FILE: tb/testbench.sv
// Testbench top for the PNG scanline unfilter: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module testbench;
  import pnguf_pkg::*;

  localparam int QUIET_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_BYTES = 1400;
  localparam int CALM_BYTES   = 200;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic [1:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [12:0] cfg_data = '0;

  int pending, checked, failures;
  int gap_odds = 0;
  int stall_odds = 0;
  int stall_left = 0;
  int quiet = 0;
  int n_images = 0;
  int n_rows = 0;
  int n_bad_rows = 0;
  int n_bytes = 0;
  // Geometry in force after clamping
  int unsigned cur_bpp = 4;
  int unsigned cur_width = 1;
  int unsigned cur_height = 1;

  png_scanline_unfilter_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  png_unfilter_checker u_check (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pending   (pending),
    .checked   (checked),
    .failures  (failures)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Receiver back-pressure in bursts of random length
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready <= (stall_left == 1);
    end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
      stall_left <= $urandom_range(1, 10);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("no beat on any channel for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, pending);
      $display("png_scanline_unfilter_top test failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic int unsigned fit(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    logic ok;
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    do begin
      @(negedge clk);
      ok = s_tready;
      @(posedge clk);
    end while (!ok);
    n_bytes++;
  endtask

  // Filter byte, then count data bytes weighted toward the extremes
  task automatic send_row(input logic [7:0] filter, input int unsigned count);
    send_byte(filter);
    for (int unsigned i = 0; i < count; i++) begin
      case ($urandom_range(0, 7))
        0:       send_byte(8'h00);
        1:       send_byte(8'hFF);
        default: send_byte(8'($urandom));
      endcase
    end
    n_rows++;
    if (filter > FILTER_MAX) n_bad_rows++;
  endtask

  task automatic set_geometry(input logic [2:0] bpp, input logic [12:0] width,
                              input logic [12:0] height);
    cfg_reg_t    regs [3];
    logic [12:0] vals [3];
    logic        ok;
    regs[0] = REG_BPP;
    regs[1] = REG_WIDTH;
    regs[2] = REG_HEIGHT;
    vals[0] = {10'd0, bpp};
    vals[1] = width;
    vals[2] = height;
    cfg_valid <= 1'b1;
    for (int i = 0; i < 3; i++) begin
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      do begin
        @(negedge clk);
        ok = cfg_ready;
        @(posedge clk);
      end while (!ok);
    end
    cfg_valid <= 1'b0;
    cur_bpp = fit(bpp, 3, MAX_BPP_DEF);
    cur_width = fit(width, 1, MAX_WIDTH_DEF);
    cur_height = fit(height, 1, MAX_HEIGHT_DEF);
  endtask

  // Drop valid, wait out every outstanding pixel beat, then let the pipeline empty
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int          odds_pick [4];
    int          base, done_so_far;
    logic [2:0]  bpp_w;
    logic [12:0] width_w, height_w;
    logic [7:0]  f;
    odds_pick = '{0, 3, 6, 12};
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // One RGBA pixel, one row, at reset geometry
    send_row(FILT_NONE, 4);
    n_images++;

    // Sub, Up, Average and Paeth plus illegal filter bytes, two RGB pixels per row
    settle();
    set_geometry(3'd3, 13'd2, 13'd6);
    send_row(FILT_PAETH, 6);
    send_row(FILT_AVG, 6);
    send_row(FILT_UP, 6);
    send_row(8'd5, 6);
    send_row(FILT_SUB, 6);
    send_row(8'hFF, 6);
    n_images++;

    // Oversized pixel and height clamp, then cut the height below the current row
    settle();
    set_geometry(3'd7, 13'd1, 13'h1FFF);
    repeat (3) send_row(8'($urandom_range(0, 4)), 4);
    settle();
    set_geometry(3'd4, 13'd1, 13'd2);
    send_row(FILT_PAETH, 4);
    n_images++;

    // Shrink the width in the middle of a row: the next byte closes it
    settle();
    set_geometry(3'd3, 13'd4, 13'd3);
    send_row(FILT_SUB, 12);
    send_row(FILT_PAETH, 5);
    settle();
    set_geometry(3'd3, 13'd2, 13'd3);
    send_byte(8'($urandom));
    send_row(FILT_AVG, 6);
    n_images++;

    base = n_bytes;
    done_so_far = 0;
    while (done_so_far < RANDOM_BYTES) begin
      if (done_so_far > RANDOM_BYTES - CALM_BYTES) begin
        gap_odds = 0;
        stall_odds = 0;
      end else begin
        gap_odds = odds_pick[$urandom_range(0, 3)];
        stall_odds = odds_pick[$urandom_range(0, 3)];
      end
      // Chain some images on the same geometry without a pause
      if ($urandom_range(0, 2) != 0) begin
        settle();
        bpp_w = ($urandom_range(0, 5) == 0) ? 3'($urandom) : 3'($urandom_range(3, 4));
        width_w = ($urandom_range(0, 9) == 0) ? 13'd0
                : 13'($urandom_range(1, ($urandom_range(0, 4) == 0) ? 40 : 6));
        height_w = ($urandom_range(0, 9) == 0) ? 13'd0 : 13'($urandom_range(1, 5));
        set_geometry(bpp_w, width_w, height_w);
      end
      for (int unsigned r = 0; r < cur_height; r++) begin
        f = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(5, 255))
                                         : 8'($urandom_range(0, 4));
        send_row(f, cur_bpp * cur_width);
      end
      n_images++;
      done_so_far = n_bytes - base;
    end

    settle();
    $display("run covered %0d images, %0d rows (%0d with an illegal filter type), %0d stream bytes",
             n_images, n_rows, n_bad_rows, n_bytes);
    $display("compared %0d pixel beats, %0d mismatched", checked, failures);
    if (failures == 0) begin
      $display("png_scanline_unfilter_top test passed");
    end else begin
      $display("png_scanline_unfilter_top test failed");
    end
    $finish;
  end

endmodule
